// ===== design/cdeq_pkg.sv =====
// Package for the circular double-ended queue.
// Holds the request and response item types, operation codes and status codes.
// No dependencies.
package cdeq_pkg;

   // Operation codes carried in the request item
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   // Status codes carried in the response item
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [31:0] pop_value;
      logic [1:0]  status;
      logic [4:0]  entry_count;
   } rsp_type;

endpackage

// ===== design/circular_double_ended_queue.sv =====
// Circular double-ended queue: ring store in a synchronous RAM plus head,
// tail and count registers, with a registered response item.
// Depends on cdeq_pkg.

// Each request item is one of push front, push rear, pop front or pop rear.
// A push, and any refused operation (push when full, pop when empty), gets
// its response loaded into the output register at the edge of acceptance;
// for a push the store write and the pointer update happen at that same
// edge, so pushes can be accepted back to back. A successful pop reads the
// store's single read port into its read-data register at acceptance, and
// the response is loaded from it on the following edge; no request is taken
// during that read cycle. A new request is accepted only while the output
// register is empty or its response is taken in the same cycle, so a stalled
// response item holds off the request side. The store has no reset; entries
// are only read after a push has written them.
module circular_double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdeq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdeq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Control states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cdeq_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0] ring_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;

   logic                  accept;
   logic                  is_push;
   logic                  is_full;
   logic                  is_empty;
   logic [DATA_WIDTH+31:0] push_ext;
   logic [DATA_WIDTH+31:0] pop_ext;
   logic [CNT_W+4:0]      count_out_ext;
   logic [CNT_W+4:0]      count_cur_ext;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_push  = (req_data.op == cdeq_pkg::OP_PUSH_FRONT) ||
                     (req_data.op == cdeq_pkg::OP_PUSH_REAR);
   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   // Width adaptation between the 32-bit item fields and the store width
   assign push_ext      = {{DATA_WIDTH{1'b0}}, req_data.push_value};
   assign wr_data       = push_ext[DATA_WIDTH-1:0];
   assign pop_ext       = {32'd0, rd_data_ff};
   assign count_out_ext = {5'd0, count_in};
   assign count_cur_ext = {5'd0, count_ff};

   // Next-state logic: pointer update, store access and response
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_push) begin
                  if (is_full) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.pop_value   = '0;
                     rsp_data_in.status      = cdeq_pkg::STATUS_OVERFLOW;
                     rsp_data_in.entry_count = count_cur_ext[4:0];
                  end else begin
                     wr_en = 1'b1;
                     if (is_empty) begin
                        head_in = '0;
                        tail_in = '0;
                        wr_addr = '0;
                     end else if (req_data.op == cdeq_pkg::OP_PUSH_FRONT) begin
                        head_in = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
                        wr_addr = head_in;
                     end else begin
                        tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                        wr_addr = tail_in;
                     end
                     count_in                = CNT_W'(count_ff + 1'b1);
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.pop_value   = '0;
                     rsp_data_in.status      = cdeq_pkg::STATUS_DONE;
                     rsp_data_in.entry_count = count_out_ext[4:0];
                  end
               end else begin
                  if (is_empty) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.pop_value   = '0;
                     rsp_data_in.status      = cdeq_pkg::STATUS_UNDERFLOW;
                     rsp_data_in.entry_count = count_cur_ext[4:0];
                  end else begin
                     rd_en = 1'b1;
                     if (req_data.op == cdeq_pkg::OP_POP_FRONT) begin
                        rd_addr = head_ff;
                        head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                     end else begin
                        rd_addr = tail_ff;
                        tail_in = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
                     end
                     count_in = CNT_W'(count_ff - 1'b1);
                     // queue drained: indices go home
                     if (count_in == '0) begin
                        head_in = '0;
                        tail_in = '0;
                     end
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            // read data is back; output register is free here
            rsp_valid_in            = 1'b1;
            rsp_data_in.pop_value   = pop_ext[31:0];
            rsp_data_in.status      = cdeq_pkg::STATUS_DONE;
            rsp_data_in.entry_count = count_cur_ext[4:0];
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Ring store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_store_ff[rd_addr];
      end
   end

   // Count never exceeds the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   // Empty queue keeps both indices at zero
   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with nonzero index");

   // The read cycle always finds the output register free
   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("pop data arrived with output register busy");

   // A refused push leaves the count untouched
   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && is_push && is_full) |=> (count_ff == $past(count_ff)))
      else $error("overflow push changed the count");

endmodule

// ===== dv/cdeq_checker.sv =====
// Checker for the circular double-ended queue: watches the request and response
// channels, predicts each response and compares it field by field.
// Depends on cdeq_pkg.
module cdeq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cdeq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cdeq_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   // Predicted deque state; 4-bit indices wrap on their own for 16 entries
   logic [31:0] deque_store [DEPTH];
   logic [3:0]  front_idx;
   logic [3:0]  rear_idx;
   logic [4:0]  fill_count;

   cdeq_pkg::rsp_type pending_results [$];
   int                error_tally = 0;

   // Apply one operation to the predicted deque and return the response it gives
   function automatic cdeq_pkg::rsp_type apply_deque_op(cdeq_pkg::req_type item);
      cdeq_pkg::rsp_type r;
      r = '{pop_value: '0, status: cdeq_pkg::STATUS_DONE, entry_count: '0};
      if (item.op == cdeq_pkg::OP_PUSH_FRONT || item.op == cdeq_pkg::OP_PUSH_REAR) begin
         if (fill_count == DEPTH) begin
            r.status = cdeq_pkg::STATUS_OVERFLOW;
         end else begin
            // first element always lands at slot 0
            if (fill_count == 0) begin
               front_idx      = '0;
               rear_idx       = '0;
               deque_store[0] = item.push_value;
            end else if (item.op == cdeq_pkg::OP_PUSH_FRONT) begin
               front_idx              = front_idx - 4'd1;
               deque_store[front_idx] = item.push_value;
            end else begin
               rear_idx              = rear_idx + 4'd1;
               deque_store[rear_idx] = item.push_value;
            end
            fill_count = fill_count + 5'd1;
         end
      end else begin
         if (fill_count == 0) begin
            r.status = cdeq_pkg::STATUS_UNDERFLOW;
         end else begin
            if (item.op == cdeq_pkg::OP_POP_FRONT) begin
               r.pop_value = deque_store[front_idx];
               front_idx   = front_idx + 4'd1;
            end else begin
               r.pop_value = deque_store[rear_idx];
               rear_idx    = rear_idx - 4'd1;
            end
            fill_count = fill_count - 5'd1;
            // emptied: both indices go back to the start
            if (fill_count == 0) begin
               front_idx = '0;
               rear_idx  = '0;
            end
         end
      end
      r.entry_count = fill_count;
      return r;
   endfunction

   // Responses are matched before requests: a response never belongs to a
   // request taken at the same edge
   always @(posedge clock) begin
      cdeq_pkg::rsp_type want;
      if (reset) begin
         front_idx  = '0;
         rear_idx   = '0;
         fill_count = '0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response item with nothing expected: %h", rsp_data);
               error_tally++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.pop_value !== want.pop_value) begin
                  $error("pop_value: expected %h, actual %h",
                         want.pop_value, rsp_data.pop_value);
                  error_tally++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  error_tally++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_tally++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(apply_deque_op(req_data));
      end
      mismatch_count      <= error_tally;
      results_outstanding <= pending_results.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the circular double-ended queue: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on cdeq_pkg, circular_double_ended_queue and cdeq_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 550;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cdeq_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cdeq_pkg::rsp_type rsp_data;

   int mismatch_count;
   int results_outstanding;
   int burst_left = 0;

   // Receiver stall pattern state
   int          stall_span = 0;
   int          stall_mode = 0;
   logic [31:0] stall_mask = '1;

   always #4 clock = ~clock;

   circular_double_ended_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cdeq_checker deque_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // Response back-pressure: modes of never, random or masked stalls
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(16, 96);
         stall_mode <= $urandom_range(0, 2);
         stall_mask <= $urandom;
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ready <= stall_mask[stall_span[4:0]];
      endcase
   end

   // Send one request item, at the start of each burst often inserting an idle gap
   task automatic issue(input logic [1:0] op, input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{op: op, push_value: value};
      do @(posedge clock); while (!req_ready);
   endtask

   // Push values lean toward all-zero and all-one now and then
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          phase_left;
      int          push_pct;
      logic [1:0]  op;
      logic [31:0] fill_vals [4];
      fill_vals = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
      phase_left = 0;
      push_pct   = 50;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops on empty, push into empty then pop to empty, fill, overflow, pops from full
      issue(cdeq_pkg::OP_POP_FRONT, 32'h1234_5678);
      issue(cdeq_pkg::OP_POP_REAR, 32'hFFFF_FFFF);
      issue(cdeq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
      issue(cdeq_pkg::OP_POP_REAR, 32'h0);
      issue(cdeq_pkg::OP_PUSH_REAR, 32'h0);
      issue(cdeq_pkg::OP_POP_FRONT, 32'h0);
      for (int i = 0; i < 16; i++)
         issue((i % 2 == 0) ? cdeq_pkg::OP_PUSH_FRONT : cdeq_pkg::OP_PUSH_REAR,
               (i < 4) ? fill_vals[i] : $urandom);
      issue(cdeq_pkg::OP_PUSH_FRONT, 32'hDEAD_0001);
      issue(cdeq_pkg::OP_PUSH_REAR, 32'hDEAD_0002);
      issue(cdeq_pkg::OP_POP_FRONT, 32'h0);
      issue(cdeq_pkg::OP_POP_REAR, 32'h0);

      // Random: phases biased toward filling, draining or neither
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 50);
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         phase_left--;
         if ($urandom_range(1, 100) <= push_pct)
            op = $urandom_range(0, 1) ? cdeq_pkg::OP_PUSH_REAR : cdeq_pkg::OP_PUSH_FRONT;
         else
            op = $urandom_range(0, 1) ? cdeq_pkg::OP_POP_REAR : cdeq_pkg::OP_POP_FRONT;
         issue(op, pick_value());
      end
      req_valid <= 1'b0;

      // Drain (the outstanding count is registered, so it trails the queue), then settle
      do @(posedge clock); while (results_outstanding != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
design/cdeq_pkg.sv
design/circular_double_ended_queue.sv
dv/cdeq_checker.sv
dv/tb_top.sv
